FILE: src/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int unsigned SigBytes = 16;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned AddrW    = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatternLow    = 8'd0,
    RegPatternHigh   = 8'd1,
    RegPatternLength = 8'd2,
    RegBaseAddress   = 8'd3
  } cfg_reg_e;

  typedef logic [SigBytes-1:0][7:0] sig_t;

  typedef struct packed {
    logic            shift;
    logic [LenW-1:0] len;
  } cell_ctl_t;

endpackage

FILE: src/wbps_cell.sv
// One window cell: holds a byte, passes it on and compares its incoming byte with its signature byte.
module wbps_cell #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned IDX         = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wbps_pkg::cell_ctl_t ctl_i,
  input  wbps_pkg::sig_t      sig_i,
  input  logic [7:0]          byte_i,
  output logic [7:0]          byte_o,
  output logic                hit_o
);

  localparam logic [5:0] IdxC = 6'(IDX);
  localparam logic [5:0] MaxC = 6'(MAX_PATTERN);

  logic [7:0] byte_q;
  logic [5:0] pos;
  logic       active;
  logic [3:0] sel;
  logic [7:0] sig_byte;

  always_comb begin
    pos      = IdxC + {1'b0, ctl_i.len};
    active   = (pos >= MaxC);
    sel      = 4'(pos - MaxC);
    sig_byte = sig_i[sel];
    hit_o    = !active || (sig_byte == 8'h00) || (sig_byte == byte_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: src/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: cell row, scan state and result pipe.
// Throughput: one byte item per cycle while the output is not stalled, including a region end in every cycle.
// A region's result is registered first in the r1 stage and then in the output register.
// The match compare runs in the row of window cells; the address add has its own stage.
// Reset clears the window, the byte count, the match state and the valid flags of the result pipe.
// The configuration registers reset to a length of one and zero otherwise.
module wildcard_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [wbps_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                last_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic [wbps_pkg::AddrW-1:0]          match_address_o
);

  localparam int unsigned LenW = wbps_pkg::LenW;
  localparam int unsigned AddrW = wbps_pkg::AddrW;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  logic [63:0]     pat_low_q, pat_high_q, base_q;
  logic [LenW-1:0] pat_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= LenW'(1);
      base_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wbps_pkg::RegPatternLow:    pat_low_q  <= cfg_data_i;
        wbps_pkg::RegPatternHigh:   pat_high_q <= cfg_data_i;
        wbps_pkg::RegPatternLength: pat_len_q  <= cfg_data_i[LenW-1:0];
        wbps_pkg::RegBaseAddress:   base_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [LenW-1:0] len_eff;

  always_comb begin
    if (pat_len_q == '0) begin
      len_eff = LenW'(1);
    end else if (pat_len_q > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = pat_len_q;
    end
  end

  logic                in_acc;
  logic                adv2;
  logic                r1_valid_q;
  logic                r1_found_q;
  logic [AddrW-1:0]    r1_offset_q;
  logic                out_valid_q;
  logic                found_q;
  logic [AddrW-1:0]    addr_q;

  assign adv2       = r1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = r1_valid_q && !adv2;
  assign in_acc     = in_valid_i && !in_stall_o;

  wbps_pkg::cell_ctl_t ctl;
  wbps_pkg::sig_t      sig;
  logic [7:0]          win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_hit;

  assign ctl.shift = in_acc;
  assign ctl.len   = len_eff;
  assign sig       = {pat_high_q, pat_low_q};

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] cell_in;
    if (k == MAX_PATTERN - 1) begin : g_head
      assign cell_in = data_byte_i;
    end else begin : g_body
      assign cell_in = win[k+1];
    end
    wbps_cell #(
      .MAX_PATTERN(MAX_PATTERN),
      .IDX        (k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .sig_i (sig),
      .byte_i(cell_in),
      .byte_o(win[k]),
      .hit_o (cell_hit[k])
    );
  end

  logic [AddrW-1:0] bytes_seen_q, bytes_seen_d;
  logic             match_seen_q, match_seen_d;
  logic [AddrW-1:0] first_off_q, first_off_d;
  logic [AddrW-1:0] len_m1;
  logic             count_ok;
  logic             new_match;
  logic [AddrW-1:0] off_new;
  logic             res_found;
  logic [AddrW-1:0] res_offset;

  always_comb begin
    len_m1     = AddrW'(len_eff - LenW'(1));
    count_ok   = !(&bytes_seen_q) && (bytes_seen_q >= len_m1);
    new_match  = !match_seen_q && count_ok && (&cell_hit);
    off_new    = bytes_seen_q - len_m1;
    res_found  = match_seen_q || new_match;
    res_offset = match_seen_q ? first_off_q : off_new;

    bytes_seen_d = bytes_seen_q;
    match_seen_d = match_seen_q;
    first_off_d  = first_off_q;
    if (in_acc) begin
      if (last_byte_i) begin
        bytes_seen_d = '0;
        match_seen_d = 1'b0;
        first_off_d  = '0;
      end else begin
        bytes_seen_d = bytes_seen_q + AddrW'(1);
        if (new_match) begin
          match_seen_d = 1'b1;
          first_off_d  = off_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      match_seen_q <= 1'b0;
      first_off_q  <= '0;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      match_seen_q <= match_seen_d;
      first_off_q  <= first_off_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
    end else if (in_acc && last_byte_i) begin
      r1_valid_q <= 1'b1;
    end else if (adv2) begin
      r1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      r1_found_q  <= res_found;
      r1_offset_q <= res_offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv2) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      found_q <= r1_found_q;
      addr_q  <= r1_found_q ? (base_q + r1_offset_q) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

  a_no_addr_without_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_address_o == '0)
    else $error("match address is nonzero without a match");

  a_region_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> bytes_seen_q == '0 && !match_seen_q)
    else $error("scan state not cleared after the region end");

  a_result_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> r1_valid_q)
    else $error("region end item did not reach the result stage");

  a_match_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_seen_q && !(in_acc && last_byte_i) |=> match_seen_q && $stable(first_off_q))
    else $error("first match offset changed within a region");

endmodule
